>>> rtl/ppq_pkg.sv
// ----------------------------------------------------------------------------
// ppq_pkg
// shared constants, payload types and status codes of the priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package ppq_pkg;

  localparam int NUM_LEVELS  = 64;
  localparam int LVL_W       = $clog2(NUM_LEVELS);
  localparam int CAPACITY    = 1024;
  localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int LIM_W       = 11;
  localparam int DATA_W      = 16;
  localparam int BYTE_W      = 26;
  localparam int DROP_W      = 32;
  localparam int STAT_W      = 3;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 11'd1024;

  typedef enum logic [STAT_W-1:0] {
    ST_QUEUED  = 3'd0,
    ST_PUSHOUT = 3'd1,
    ST_DROPPED = 3'd2,
    ST_DEQUEUE = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

  typedef struct packed {
    logic              action;
    logic [DATA_W-1:0] prio;
    logic [DATA_W-1:0] packet_tag;
    logic [DATA_W-1:0] packet_len;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] out_tag;
    logic [DATA_W-1:0] out_len;
    logic [LVL_W-1:0]  out_prio;
    logic [CNT_W-1:0]  queue_count;
    logic [BYTE_W-1:0] backlog_bytes;
    logic [DROP_W-1:0] level_drops;
    logic [BYTE_W-1:0] level_backlog;
  } out_item_t;

  // occupancy bounds
  typedef struct packed {
    logic             any;
    logic [LVL_W-1:0] highest;
    logic [LVL_W-1:0] lowest;
  } bounds_t;

endpackage

`default_nettype wire

>>> rtl/ppq_ifs.sv
// ----------------------------------------------------------------------------
// ppq channel interfaces
// valid/ready channels for input beats, result beats and the limit register
// ----------------------------------------------------------------------------
`default_nettype none

interface ppq_in_if import ppq_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppq_out_if import ppq_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppq_cfg_if import ppq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/priority_pushout_queue_core.sv
// ----------------------------------------------------------------------------
// priority_pushout_queue_core
// strict priority descriptor queue with push-out under a global packet limit
// ----------------------------------------------------------------------------
// usage:
//   in_if  : one beat per operation (enqueue with prio/tag/len, or dequeue)
//   out_if : exactly one result beat per input beat, in order
//   cfg_if : queue_limit write, always ready; write only while idle
// timing:
//   one operation is in flight at a time; in_if.ready is high only when
//   the sequencer is idle
//   enqueue/drop/empty: result register loaded in S_REC after the level
//   record read; dequeue: in S_SLOT after the slot read; push-out: in S_APP
//   after the read of the target level record; with an open receiver the
//   next beat is taken once the sequencer is back in S_IDLE, so a new item
//   is accepted only once the last one has loaded its result; the steps follow
//   the synchronous reads of the level record and slot link memories
// stall:
//   the result register holds a beat until taken; the next item can be
//   accepted meanwhile and waits in its last step until the register frees
// reset:
//   rst_n clears counters, occupancy and the level valid bits; slot memories
//   need no clear, free slots come from the free stack and, when it is empty,
//   from a fresh-slot counter, so there is no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module priority_pushout_queue_core import ppq_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ppq_in_if.sink     in_if,
  ppq_out_if.source  out_if,
  ppq_cfg_if.sink    cfg_if
);

  // per-level record
  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
    logic [CNT_W-1:0]  count;
    logic [BYTE_W-1:0] bytes;
    logic [DROP_W-1:0] drops;
  } lrec_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LVL  = 5'b00010,
    S_REC  = 5'b00100,
    S_SLOT = 5'b01000,
    S_APP  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    OP_ENQ, OP_DROP, OP_PUSH, OP_DEQ, OP_EMPTY
  } op_t;

  // control state
  state_t                  state_r, state_nxt;
  op_t                     op_r, op_nxt;
  logic [LIM_W-1:0]        limit_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]       bytes_r, bytes_nxt;
  logic [NUM_LEVELS-1:0]   occ_r, occ_nxt;
  logic [NUM_LEVELS-1:0]   lvalid_r;
  logic [CNT_W-1:0]        fresh_r, fresh_nxt;
  logic [CNT_W-1:0]        free_cnt_r, free_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // item context
  logic [LVL_W-1:0]        prio_r, prio_nxt;
  logic [LVL_W-1:0]        lvl_r, lvl_nxt;
  logic [DATA_W-1:0]       tag_r, tag_nxt;
  logic [DATA_W-1:0]       len_r, len_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  lrec_t                   save_r, save_nxt;
  logic [DATA_W-1:0]       otag_r, otag_nxt;
  logic [DATA_W-1:0]       olen_r, olen_nxt;
  out_item_t               out_r, out_nxt;

  // level record memory
  lrec_t                   lmem [NUM_LEVELS];
  logic                    lm_we, lm_re;
  logic [LVL_W-1:0]        lm_waddr, lm_raddr;
  lrec_t                   lm_wdata, lm_rdata_r, lrec_rd;
  logic                    lm_rvalid_r;

  // slot memories: link words, tag and length
  logic [SLOT_W-1:0]       nmem [CAPACITY];
  logic [SLOT_W-1:0]       pmem [CAPACITY];
  logic [DATA_W-1:0]       tmem [CAPACITY];
  logic [DATA_W-1:0]       vmem [CAPACITY];
  logic                    nm_we, sm_we, sm_re;
  logic [SLOT_W-1:0]       nm_waddr, nm_wdata, sm_waddr, sm_raddr;
  logic [SLOT_W-1:0]       sm_prev_w;
  logic [DATA_W-1:0]       sm_tag_w, sm_len_w;
  logic [SLOT_W-1:0]       nxt_rd_r, prv_rd_r;
  logic [DATA_W-1:0]       tag_rd_r, len_rd_r;

  // free slot stack (released slots only)
  logic [SLOT_W-1:0]       fmem [CAPACITY];
  logic                    fs_we, fs_re;
  logic [SLOT_W-1:0]       fs_waddr, fs_wdata, fs_raddr, fs_rd_r;

  bounds_t                 bnd;
  logic                    out_free;
  logic [LVL_W-1:0]        p_cl;
  logic                    room;

  ppq_level_enc u_enc (
    .occ    (occ_r),
    .bounds (bnd)
  );

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;
  assign out_free     = !out_valid_r || out_if.ready;
  assign lrec_rd      = lm_rvalid_r ? lm_rdata_r : '0;

  // clamp priority to the top level
  assign p_cl = (in_if.data.prio > DATA_W'(NUM_LEVELS - 1)) ?
                LVL_W'(NUM_LEVELS - 1) : in_if.data.prio[LVL_W-1:0];
  // below the effective limit (min of register and capacity)
  assign room = (32'(cnt_r) < 32'(limit_r)) && (32'(cnt_r) < 32'(CAPACITY));

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    lrec_t             rn;
    logic [SLOT_W-1:0] s;

    state_nxt    = state_r;
    op_nxt       = op_r;
    cnt_nxt      = cnt_r;
    bytes_nxt    = bytes_r;
    occ_nxt      = occ_r;
    fresh_nxt    = fresh_r;
    free_cnt_nxt = free_cnt_r;
    prio_nxt     = prio_r;
    lvl_nxt      = lvl_r;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    slot_nxt     = slot_r;
    save_nxt     = save_r;
    otag_nxt     = otag_r;
    olen_nxt     = olen_r;
    out_nxt      = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;

    lm_we = 1'b0; lm_waddr = lvl_r; lm_wdata = '0;
    lm_re = 1'b0; lm_raddr = lvl_r;
    nm_we = 1'b0; nm_waddr = '0;    nm_wdata = '0;
    sm_we = 1'b0; sm_waddr = '0;    sm_prev_w = '0;
    sm_tag_w = tag_r; sm_len_w = len_r;
    sm_re = 1'b0; sm_raddr = '0;
    fs_we = 1'b0; fs_waddr = free_cnt_r[SLOT_W-1:0]; fs_wdata = slot_r;
    fs_re = 1'b0; fs_raddr = SLOT_W'(free_cnt_r - CNT_W'(1));
    rn = lrec_rd;
    s  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          prio_nxt = p_cl;
          tag_nxt  = in_if.data.packet_tag;
          len_nxt  = in_if.data.packet_len;
          if (in_if.data.action == ACT_ENQ) begin
            lvl_nxt = p_cl;
            if (room) begin
              op_nxt = OP_ENQ;
            end else if (p_cl <= bnd.lowest || !bnd.any) begin
              op_nxt = OP_DROP;
            end else begin
              op_nxt  = OP_PUSH;
              lvl_nxt = bnd.lowest;
            end
          end else begin
            lvl_nxt = bnd.highest;
            op_nxt  = bnd.any ? OP_DEQ : OP_EMPTY;
          end
          state_nxt = S_LVL;
        end
      end

      S_LVL: begin
        lm_re     = 1'b1;
        fs_re     = (free_cnt_r != '0);
        state_nxt = S_REC;
      end

      S_REC: begin
        case (op_r)
          OP_EMPTY: begin
            if (out_free) begin
              out_nxt = '{status: ST_EMPTY, out_tag: '0, out_len: '0, out_prio: '0,
                          queue_count: cnt_r, backlog_bytes: bytes_r,
                          level_drops: '0, level_backlog: '0};
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          OP_DROP: begin
            if (out_free) begin
              rn.drops = lrec_rd.drops + DROP_W'(1);
              lm_we = 1'b1; lm_wdata = rn;
              out_nxt = '{status: ST_DROPPED, out_tag: tag_r, out_len: len_r,
                          out_prio: lvl_r, queue_count: cnt_r, backlog_bytes: bytes_r,
                          level_drops: rn.drops, level_backlog: rn.bytes};
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          OP_ENQ: begin
            if (out_free) begin
              if (free_cnt_r != '0) begin
                s = fs_rd_r;
                free_cnt_nxt = free_cnt_r - CNT_W'(1);
              end else begin
                s = fresh_r[SLOT_W-1:0];
                fresh_nxt = fresh_r + CNT_W'(1);
              end
              sm_we = 1'b1; sm_waddr = s;
              sm_prev_w = (lrec_rd.count == '0) ? s : lrec_rd.tail;
              nm_we = (lrec_rd.count != '0); nm_waddr = lrec_rd.tail; nm_wdata = s;
              if (lrec_rd.count == '0) rn.head = s;
              rn.tail  = s;
              rn.count = lrec_rd.count + CNT_W'(1);
              rn.bytes = lrec_rd.bytes + BYTE_W'(len_r);
              lm_we = 1'b1; lm_wdata = rn;
              occ_nxt[lvl_r] = 1'b1;
              cnt_nxt   = cnt_r + CNT_W'(1);
              bytes_nxt = bytes_r + BYTE_W'(len_r);
              out_nxt = '{status: ST_QUEUED, out_tag: tag_r, out_len: len_r,
                          out_prio: lvl_r, queue_count: cnt_nxt, backlog_bytes: bytes_nxt,
                          level_drops: rn.drops, level_backlog: rn.bytes};
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            // push-out takes the tail, dequeue the head
            s = (op_r == OP_DEQ) ? lrec_rd.head : lrec_rd.tail;
            sm_re     = 1'b1; sm_raddr = s;
            slot_nxt  = s;
            save_nxt  = lrec_rd;
            state_nxt = S_SLOT;
          end
        endcase
      end

      S_SLOT: begin
        rn = save_r;
        rn.count = save_r.count - CNT_W'(1);
        rn.bytes = save_r.bytes - BYTE_W'(len_rd_r);
        if (op_r == OP_DEQ) begin
          if (out_free) begin
            if (save_r.count > CNT_W'(1)) rn.head = nxt_rd_r;
            lm_we = 1'b1; lm_wdata = rn;
            fs_we = 1'b1;
            free_cnt_nxt = free_cnt_r + CNT_W'(1);
            if (rn.count == '0) occ_nxt[lvl_r] = 1'b0;
            cnt_nxt   = cnt_r - CNT_W'(1);
            bytes_nxt = bytes_r - BYTE_W'(len_rd_r);
            out_nxt = '{status: ST_DEQUEUE, out_tag: tag_rd_r, out_len: len_rd_r,
                        out_prio: lvl_r, queue_count: cnt_nxt, backlog_bytes: bytes_nxt,
                        level_drops: rn.drops, level_backlog: rn.bytes};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          // push-out: retire the tail, keep its slot for the incoming packet
          if (save_r.count > CNT_W'(1)) rn.tail = prv_rd_r;
          rn.drops = save_r.drops + DROP_W'(1);
          lm_we = 1'b1; lm_wdata = rn;
          save_nxt = rn;
          otag_nxt = tag_rd_r;
          olen_nxt = len_rd_r;
          if (rn.count == '0) occ_nxt[lvl_r] = 1'b0;
          bytes_nxt = bytes_r - BYTE_W'(len_rd_r);
          lm_re = 1'b1; lm_raddr = prio_r;
          state_nxt = S_APP;
        end
      end

      S_APP: begin
        if (out_free) begin
          s = slot_r;
          sm_we = 1'b1; sm_waddr = s;
          sm_prev_w = (lrec_rd.count == '0) ? s : lrec_rd.tail;
          nm_we = (lrec_rd.count != '0); nm_waddr = lrec_rd.tail; nm_wdata = s;
          if (lrec_rd.count == '0) rn.head = s;
          rn.tail  = s;
          rn.count = lrec_rd.count + CNT_W'(1);
          rn.bytes = lrec_rd.bytes + BYTE_W'(len_r);
          lm_we = 1'b1; lm_waddr = prio_r; lm_wdata = rn;
          occ_nxt[prio_r] = 1'b1;
          bytes_nxt = bytes_r + BYTE_W'(len_r);
          out_nxt = '{status: ST_PUSHOUT, out_tag: otag_r, out_len: olen_r,
                      out_prio: lvl_r, queue_count: cnt_r, backlog_bytes: bytes_nxt,
                      level_drops: save_r.drops, level_backlog: save_r.bytes};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_EMPTY;
      limit_r     <= LIMIT_RESET;
      cnt_r       <= '0;
      bytes_r     <= '0;
      occ_r       <= '0;
      lvalid_r    <= '0;
      fresh_r     <= '0;
      free_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      bytes_r     <= bytes_nxt;
      occ_r       <= occ_nxt;
      fresh_r     <= fresh_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) limit_r <= cfg_if.data;
      if (lm_we) lvalid_r[lm_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    lvl_r  <= lvl_nxt;
    tag_r  <= tag_nxt;
    len_r  <= len_nxt;
    slot_r <= slot_nxt;
    save_r <= save_nxt;
    otag_r <= otag_nxt;
    olen_r <= olen_nxt;
    out_r  <= out_nxt;
  end

  // level record memory
  always_ff @(posedge clk) begin
    if (lm_we) lmem[lm_waddr] <= lm_wdata;
    if (lm_re) begin
      lm_rdata_r  <= lmem[lm_raddr];
      lm_rvalid_r <= lvalid_r[lm_raddr];
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (nm_we) nmem[nm_waddr] <= nm_wdata;
    if (sm_we) begin
      pmem[sm_waddr] <= sm_prev_w;
      tmem[sm_waddr] <= sm_tag_w;
      vmem[sm_waddr] <= sm_len_w;
    end
    if (sm_re) begin
      nxt_rd_r <= nmem[sm_raddr];
      prv_rd_r <= pmem[sm_raddr];
      tag_rd_r <= tmem[sm_raddr];
      len_rd_r <= vmem[sm_raddr];
    end
  end

  // free stack
  always_ff @(posedge clk) begin
    if (fs_we) fmem[fs_waddr] <= fs_wdata;
    if (fs_re) fs_rd_r <= fmem[fs_raddr];
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(CAPACITY))
    else $error("queue count beyond capacity");

  // the push-out append step may briefly see the map empty
  a_occ_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_APP) |-> ((occ_r == '0) == (cnt_r == '0)))
    else $error("occupancy map disagrees with queue count");

  a_slot_cons: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_cnt_r) + 32'(cnt_r) == 32'(fresh_r))
    else $error("slot accounting lost a slot");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("accepted a beat while busy");

endmodule

`default_nettype wire

>>> rtl/ppq_level_enc.sv
// ----------------------------------------------------------------------------
// ppq_level_enc
// priority encoders giving highest and lowest occupied level
// ----------------------------------------------------------------------------
`default_nettype none

module ppq_level_enc import ppq_pkg::*; (
  input  wire logic [NUM_LEVELS-1:0] occ,
  output bounds_t                    bounds
);

  always_comb begin
    bounds.any     = |occ;
    bounds.highest = '0;
    bounds.lowest  = LVL_W'(NUM_LEVELS - 1);
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (occ[i]) bounds.highest = LVL_W'(i);
    end
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (occ[i]) bounds.lowest = LVL_W'(i);
    end
  end

endmodule

`default_nettype wire

>>> sim/priority_pushout_queue_core_tb.sv
// ----------------------------------------------------------------------------
// priority_pushout_queue_core_tb
// drives enqueue/dequeue beats and queue_limit writes into the strict
// priority queue and checks every result beat against a per-level fifo
// model with push-out, drop counters and byte backlogs
// ----------------------------------------------------------------------------
`default_nettype none

module priority_pushout_queue_core_tb;
  import ppq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;

  ppq_in_if  in_if();
  ppq_out_if out_if();
  ppq_cfg_if cfg_if();

  priority_pushout_queue_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // descriptor held in one level fifo of the model
  typedef struct packed {
    logic [DATA_W-1:0] tag;
    logic [DATA_W-1:0] len;
  } desc_t;

  // model state
  desc_t             level_fifo[NUM_LEVELS][$];
  logic [DROP_W-1:0] drop_cnt[NUM_LEVELS];
  logic [BYTE_W-1:0] level_bytes[NUM_LEVELS];
  logic [BYTE_W-1:0] all_bytes;
  int                all_count;
  logic [LIM_W-1:0]  limit_reg;

  out_item_t pending_results[$];
  int        n_errors;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_idle_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // lowest occupied level, NUM_LEVELS-1 when nothing is queued
  function automatic int lowest_occupied();
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (level_fifo[l].size() != 0) return l;
    end
    return NUM_LEVELS - 1;
  endfunction

  function automatic int highest_occupied();
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (level_fifo[l].size() != 0) return l;
    end
    return 0;
  endfunction

  // work out the result of one accepted beat and advance the model
  function automatic out_item_t queue_step(in_item_t it);
    out_item_t r;
    int        lv;
    int        lp;
    int        eff_limit;
    desc_t     d;
    logic      lvl_info;
    r = '0;
    lvl_info = 1'b1;
    lv = 0;
    if (it.action == ACT_ENQ) begin
      // clamp priority to the top level
      lv = (it.prio > NUM_LEVELS - 1) ? NUM_LEVELS - 1 : int'(it.prio);
      eff_limit = (limit_reg > CAPACITY) ? CAPACITY : int'(limit_reg);
      d.tag = it.packet_tag;
      d.len = it.packet_len;
      r.out_tag = d.tag;
      r.out_len = d.len;
      lp = lowest_occupied();
      if (all_count < eff_limit && all_count < CAPACITY) begin
        level_fifo[lv].push_back(d);
        level_bytes[lv] += d.len;
        all_bytes += d.len;
        all_count++;
        r.status = ST_QUEUED;
      end else if (lv <= lp || level_fifo[lp].size() == 0) begin
        drop_cnt[lv]++;
        r.status = ST_DROPPED;
      end else begin
        // push out the tail of the lowest occupied level, then append
        desc_t victim;
        victim = level_fifo[lp].pop_back();
        level_bytes[lp] -= victim.len;
        all_bytes -= victim.len;
        drop_cnt[lp]++;
        level_fifo[lv].push_back(d);
        level_bytes[lv] += d.len;
        all_bytes += d.len;
        r.status = ST_PUSHOUT;
        r.out_tag = victim.tag;
        r.out_len = victim.len;
        lv = lp;
      end
    end else begin
      lv = highest_occupied();
      if (level_fifo[lv].size() == 0) begin
        r.status = ST_EMPTY;
        lvl_info = 1'b0;
        lv = 0;
      end else begin
        d = level_fifo[lv].pop_front();
        level_bytes[lv] -= d.len;
        all_bytes -= d.len;
        all_count--;
        r.status = ST_DEQUEUE;
        r.out_tag = d.tag;
        r.out_len = d.len;
      end
    end
    r.out_prio      = lv[LVL_W-1:0];
    r.queue_count   = all_count[CNT_W-1:0];
    r.backlog_bytes = all_bytes;
    r.level_drops   = lvl_info ? drop_cnt[lv] : '0;
    r.level_backlog = lvl_info ? level_bytes[lv] : '0;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      n_errors++;
    end
  endtask

  // monitor: predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    logic      moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        pending_results.push_back(queue_step(in_if.data));
        moved = 1'b1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        limit_reg = cfg_if.data;
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        got = out_if.data;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d tag 0x%0h",
                 got.status, got.out_tag);
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("out_tag", 32'(want.out_tag), 32'(got.out_tag));
          check_field("out_len", 32'(want.out_len), 32'(got.out_len));
          check_field("out_prio", 32'(want.out_prio), 32'(got.out_prio));
          check_field("queue_count", 32'(want.queue_count), 32'(got.queue_count));
          check_field("backlog_bytes", 32'(want.backlog_bytes),
                      32'(got.backlog_bytes));
          check_field("level_drops", want.level_drops, got.level_drops);
          check_field("level_backlog", 32'(want.level_backlog),
                      32'(got.level_backlog));
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog on cycles with no beat moving anywhere
  always @(posedge clk) begin
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("priority_pushout_queue_core_tb: FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      out_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // send one beat, hold it until accepted, then maybe leave a gap
  task automatic send_beat(logic act, logic [15:0] prio, logic [15:0] tag,
                           logic [15:0] len);
    @(negedge clk);
    in_if.data.action     = act;
    in_if.data.prio       = prio;
    in_if.data.packet_tag = tag;
    in_if.data.packet_len = len;
    in_if.valid           = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    in_if.valid = 1'b0;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
  endtask

  task automatic enq(logic [15:0] prio, logic [15:0] tag, logic [15:0] len);
    send_beat(ACT_ENQ, prio, tag, len);
  endtask

  task automatic deq();
    send_beat(ACT_DEQ, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // limit writes only once every expected result is back and the block settled
  task automatic write_limit(logic [LIM_W-1:0] value);
    wait (pending_results.size() == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_if.data  = value;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // random priority: mostly a few low levels, sometimes anything
  function automatic logic [15:0] pick_prio();
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(NUM_LEVELS - 1));
      default: return 16'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_mix(int n, int enq_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < enq_pct) enq(pick_prio(), 16'($urandom), pick_len());
      else deq();
    end
  endtask

  // extremes of every field, empty dequeue, clamp, zero limit
  task automatic test_directed();
    deq();
    enq(16'd0, 16'h0000, 16'h0000);
    enq(16'hffff, 16'hffff, 16'hffff);
    enq(16'd63, 16'h1234, 16'd100);
    enq(16'd64, 16'habcd, 16'd7);
    enq(16'd5, 16'h5555, 16'haaaa);
    repeat (6) deq();
    write_limit(11'd0);
    enq(16'd10, 16'h0001, 16'd1);
    enq(16'd0, 16'h0002, 16'd2);
    deq();
    write_limit(11'd1);
    enq(16'd0, 16'h0010, 16'd10);
    enq(16'd0, 16'h0011, 16'd11);
    // single-level full queue: pushed-out level was also the highest
    enq(16'd9, 16'h0012, 16'd12);
    enq(16'd9, 16'h0013, 16'd13);
    enq(16'd3, 16'h0014, 16'd14);
    deq();
    deq();
  endtask

  // small limits so the full path dominates
  task automatic test_pushout();
    write_limit(11'd3);
    random_mix(150, 70);
    write_limit(11'd8);
    random_mix(150, 65);
  endtask

  // limit above capacity: the pool bounds the queue
  task automatic test_capacity();
    write_limit(11'd2047);
    for (int i = 0; i < CAPACITY + 6; i++) enq(pick_prio(), 16'($urandom), pick_len());
    random_mix(30, 60);
  endtask

  // limit lowered below the current count
  task automatic test_limit_lowered();
    write_limit(11'd4);
    random_mix(120, 50);
  endtask

  task automatic test_random_phases();
    write_limit(11'd6);
    send_idle_pct = 61; recv_idle_pct = 27;
    random_mix(90, 55);
    write_limit(LIMIT_RESET);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_mix(90, 45);
    write_limit(11'd2);
    random_mix(60, 60);
  endtask

  initial begin
    n_errors      = 0;
    quiet_cycles  = 0;
    send_idle_pct = 27;
    recv_idle_pct = 61;
    limit_reg     = LIMIT_RESET;
    all_bytes     = '0;
    all_count     = 0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      drop_cnt[l]    = '0;
      level_bytes[l] = '0;
    end
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_pushout();
    test_capacity();
    test_limit_lowered();
    test_random_phases();

    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("priority_pushout_queue_core_tb: PASS");
    end else begin
      $display("priority_pushout_queue_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
